[rtl/lrt_pkg.sv]
// Shared types and codes for the LRU replacement tracker.
package lrt_pkg;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;

  // Fixed field widths of the beats
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INS_HIT,
    CMD_INS_NEW,
    CMD_EVICT,
    CMD_ERASE
  } lrt_cmd_e;

  // Status a cell hands to its neighbour: own valid bit and cumulative hit
  typedef struct packed {
    logic valid;
    logic hit;
  } lrt_link_t;

endpackage

[rtl/lrt_cell.sv]
// One slot of the recency row: key, valid bit and neighbour shifting.
module lrt_cell #(
  parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrt_pkg::lrt_cmd_e   cmd_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  lrt_pkg::lrt_link_t  from_up_i,
  input  logic [KEY_BITS-1:0] up_key_i,
  input  lrt_pkg::lrt_link_t  from_dn_i,
  input  logic [KEY_BITS-1:0] dn_key_i,
  output lrt_pkg::lrt_link_t  to_dn_o,
  output lrt_pkg::lrt_link_t  to_up_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic                match_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                valid_q, valid_d;
  logic                match;

  // Compare the held key against the search key
  assign match = valid_q && (key_q == key_i);

  // Pass cumulative hit flags both ways along the row
  assign to_dn_o.valid = valid_q;
  assign to_dn_o.hit   = from_up_i.hit | match;
  assign to_up_o.valid = valid_q;
  assign to_up_o.hit   = from_dn_i.hit | match;
  assign key_o         = key_q;
  assign match_o       = match;

  // Pick the next slot contents from the command and the neighbours
  always_comb begin
    key_d   = key_q;
    valid_d = valid_q;
    unique case (cmd_i)
      lrt_pkg::CMD_INS_HIT: begin
        // slots at and above the hit move down one
        if (match || from_dn_i.hit) begin
          key_d = up_key_i;
        end
      end
      lrt_pkg::CMD_INS_NEW: begin
        // used slots plus the first free one move down one
        if (valid_q || from_up_i.valid) begin
          key_d   = up_key_i;
          valid_d = 1'b1;
        end
      end
      lrt_pkg::CMD_EVICT: begin
        // drop the last used slot
        valid_d = valid_q & from_dn_i.valid;
      end
      lrt_pkg::CMD_ERASE: begin
        // slots at and below the hit move up one
        if (match || from_up_i.hit) begin
          key_d   = dn_key_i;
          valid_d = from_dn_i.valid;
        end
      end
      default: begin
        key_d   = key_q;
        valid_d = valid_q;
      end
    endcase
  end

  // Hold the valid bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the key
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[rtl/lru_replacement_tracker_top.sv]
// LRU replacement tracker: row of key cells with a registered result beat.
// The result beat appears in the cycle after the input beat is taken.
// Throughput: one operation per cycle; all cells compare the key in parallel and
// shift together in that same cycle, so the row settles in a single step.
// Input stalls only while a finished result waits on a stalled output.
// Reset clears every valid bit and the count at once; keys need no clearing.
module lru_replacement_tracker_top #(
  parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lrt_pkg::KIND_W-1:0]     kind_i,
  input  logic [lrt_pkg::KEY_W-1:0]      key_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lrt_pkg::STATUS_W-1:0]   status_o,
  output logic [lrt_pkg::KEY_W-1:0]      victim_key_o,
  output logic [lrt_pkg::OCC_W-1:0]      occupancy_o
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(ENTRIES);

  logic                      accept;
  logic [KEY_BITS-1:0]       op_key;
  lrt_pkg::lrt_cmd_e         cmd;
  lrt_pkg::lrt_link_t        up_in   [ENTRIES];
  lrt_pkg::lrt_link_t        dn_in   [ENTRIES];
  lrt_pkg::lrt_link_t        to_dn   [ENTRIES];
  lrt_pkg::lrt_link_t        to_up   [ENTRIES];
  logic [KEY_BITS-1:0]       up_key  [ENTRIES];
  logic [KEY_BITS-1:0]       dn_key  [ENTRIES];
  logic [KEY_BITS-1:0]       cell_key[ENTRIES];
  logic [ENTRIES-1:0]        valid_vec;
  logic [ENTRIES-1:0]        match_vec;
  logic                      hit_any;
  logic [KEY_BITS-1:0]       victim_full;
  logic [lrt_pkg::KEY_W-1:0] victim_fld;
  logic [CW-1:0]             count_q, count_d;
  logic [lrt_pkg::OCC_W-1:0] occ_fld;
  logic [lrt_pkg::STATUS_W-1:0] status_d;
  logic                      out_valid_q;
  logic [lrt_pkg::STATUS_W-1:0] status_q;
  logic [lrt_pkg::KEY_W-1:0] victim_q;
  logic [lrt_pkg::OCC_W-1:0] occ_q;

  // Take a beat unless a finished result is held back
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Fit the key field to the stored key width
  if (KEY_BITS <= lrt_pkg::KEY_W) begin : g_key_narrow
    assign op_key = key_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign op_key = {{(KEY_BITS - lrt_pkg::KEY_W){1'b0}}, key_i};
  end

  // Build the cell row and its neighbour links
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign up_in[i]  = '{valid: 1'b1, hit: 1'b0};
      assign up_key[i] = op_key;
    end else begin : g_mid_up
      assign up_in[i]  = to_dn[i-1];
      assign up_key[i] = cell_key[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign dn_in[i]  = '{valid: 1'b0, hit: 1'b0};
      assign dn_key[i] = '0;
    end else begin : g_mid_dn
      assign dn_in[i]  = to_up[i+1];
      assign dn_key[i] = cell_key[i+1];
    end

    lrt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .key_i    (op_key),
      .from_up_i(up_in[i]),
      .up_key_i (up_key[i]),
      .from_dn_i(dn_in[i]),
      .dn_key_i (dn_key[i]),
      .to_dn_o  (to_dn[i]),
      .to_up_o  (to_up[i]),
      .key_o    (cell_key[i]),
      .match_o  (match_vec[i])
    );

    assign valid_vec[i] = to_dn[i].valid;
  end

  assign hit_any = to_dn[ENTRIES-1].hit;

  // Select the key of the last used slot
  always_comb begin
    victim_full = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_vec[i] && !dn_in[i].valid) begin
        victim_full = victim_full | cell_key[i];
      end
    end
  end

  // Decode the operation into a row command, status and new count
  always_comb begin
    cmd      = lrt_pkg::CMD_HOLD;
    status_d = lrt_pkg::STATUS_MISS;
    count_d  = count_q;
    if (accept) begin
      priority if (kind_i == lrt_pkg::KIND_INSERT) begin
        priority if (hit_any) begin
          cmd      = lrt_pkg::CMD_INS_HIT;
          status_d = lrt_pkg::STATUS_DONE;
        end else if (count_q == FullCount) begin
          status_d = lrt_pkg::STATUS_FULL;
        end else begin
          cmd      = lrt_pkg::CMD_INS_NEW;
          status_d = lrt_pkg::STATUS_DONE;
          count_d  = count_q + CW'(1);
        end
      end else if (kind_i == lrt_pkg::KIND_EVICT) begin
        if (count_q != '0) begin
          cmd      = lrt_pkg::CMD_EVICT;
          status_d = lrt_pkg::STATUS_DONE;
          count_d  = count_q - CW'(1);
        end
      end else if (kind_i == lrt_pkg::KIND_ERASE) begin
        if (hit_any) begin
          cmd      = lrt_pkg::CMD_ERASE;
          status_d = lrt_pkg::STATUS_DONE;
          count_d  = count_q - CW'(1);
        end
      end else begin
        status_d = lrt_pkg::STATUS_MISS;
      end
    end
  end

  // Fit the victim key and count to their fields
  if (KEY_BITS >= lrt_pkg::KEY_W) begin : g_vic_wide
    assign victim_fld = victim_full[lrt_pkg::KEY_W-1:0];
  end else begin : g_vic_narrow
    assign victim_fld = {{(lrt_pkg::KEY_W - KEY_BITS){1'b0}}, victim_full};
  end

  if (CW >= lrt_pkg::OCC_W) begin : g_occ_wide
    assign occ_fld = count_d[lrt_pkg::OCC_W-1:0];
  end else begin : g_occ_narrow
    assign occ_fld = {{(lrt_pkg::OCC_W - CW){1'b0}}, count_d};
  end

  // Advance the occupancy count and the output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      victim_q <= (cmd == lrt_pkg::CMD_EVICT) ? victim_fld : '0;
      occ_q    <= occ_fld;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign victim_key_o = victim_q;
  assign occupancy_o  = occ_q;

  // Count never passes the number of cells
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FullCount)
    else $error("occupancy count beyond capacity");

  // Valid bits agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("valid bits disagree with count");

  // Keys held are distinct, so at most one cell matches
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match_vec))
    else $error("search key matches more than one cell");

  // A successful evict shrinks the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == lrt_pkg::CMD_EVICT) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("evict did not shrink count");

endmodule
